/* sv/dmbd_pkg.sv */
package dmbd_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        new_table;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
  } in_t;

  typedef struct packed {
    logic             anomaly;
    logic [CAP_W-1:0] entry_count;
    logic             dropped;
  } out_t;

  // request travelling down the cell row
  typedef struct packed {
    logic             valid;
    logic             check;
    logic             hit;
    logic [CAP_W-1:0] count;
    logic [31:0]      ip;
    logic [47:0]      mac;
  } token_t;

endpackage

/* sv/dmbd_cell.sv */
module dmbd_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  dmbd_pkg::token_t token_in,
  output dmbd_pkg::token_t token_out
);
  import dmbd_pkg::*;

  logic [47:0] mac;
  logic [31:0] ip;
  logic        occupied;
  logic        conflict;
  token_t      token_next;

  // entry is part of the current table only below the request's count
  assign occupied = 32'(token_in.count) > INDEX;
  assign conflict = token_in.check && occupied && (mac == token_in.mac) && (ip != token_in.ip);

  always_comb begin
    token_next = token_in;
    token_next.hit = token_in.hit | conflict;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.valid <= 1'b0;
    end else begin
      token_out.valid <= token_next.valid;
    end
    token_out.check <= token_next.check;
    token_out.hit   <= token_next.hit;
    token_out.count <= token_next.count;
    token_out.ip    <= token_next.ip;
    token_out.mac   <= token_next.mac;
    if (token_in.valid && (32'(token_in.count) == INDEX)) begin
      mac <= token_in.mac;
      ip  <= token_in.ip;
    end
  end

endmodule

/* sv/duplicate_mac_binding_detector.sv */
// Duplicate MAC binding detector. A request is taken when start is high and busy is low.
// A request the table has room for walks a row of TABLE_DEPTH cells, one cell per cycle,
// is checked against every stored entry unless its MAC is broadcast, and is written into
// its own cell on the way; its result is registered from the last cell, with busy high
// until then. A dropped request (table full) gets its result in the cycle after start;
// busy stays low. Each result is on the result port for exactly one cycle, marked by
// result_valid, and the receiver cannot stall it. The capacity register takes writes in
// any cycle (cfg_ready is always high) and should only be changed while busy is low.
module duplicate_mac_binding_detector #(
  parameter int unsigned TABLE_DEPTH = dmbd_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  dmbd_pkg::in_t             request,
  output logic                      result_valid,
  output dmbd_pkg::out_t            result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dmbd_pkg::CAP_W-1:0] cfg_data
);
  import dmbd_pkg::*;

  typedef enum logic {IDLE, SCAN} state_t;

  state_t           state;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] stored_count;
  logic             anomaly_seen;

  logic [CAP_W-1:0] base_count;
  logic             base_anomaly;
  logic             cap_limited;
  logic             drop;
  logic             take;
  token_t           chain [0:TABLE_DEPTH];
  token_t           tail;

  assign cfg_ready = 1'b1;
  assign busy      = (state == SCAN);
  assign take      = start && !busy;

  assign base_count   = request.new_table ? '0 : stored_count;
  assign base_anomaly = request.new_table ? 1'b0 : anomaly_seen;
  // capacity above the row length acts as the row length
  assign cap_limited  = 32'(capacity) > TABLE_DEPTH;
  assign drop = cap_limited ? (32'(base_count) >= TABLE_DEPTH) : (base_count >= capacity);

  always_comb begin
    chain[0].valid = take && !drop;
    chain[0].check = request.mac_address != BCAST_MAC;
    chain[0].hit   = 1'b0;
    chain[0].count = base_count;
    chain[0].ip    = request.ip_address;
    chain[0].mac   = request.mac_address;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dmbd_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .token_in (chain[i]),
      .token_out(chain[i+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      capacity     <= CAP_RESET;
      stored_count <= '0;
      anomaly_seen <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      unique case (state)
        IDLE: begin
          if (take) begin
            stored_count <= base_count;
            anomaly_seen <= base_anomaly;
            if (drop) begin
              result_valid       <= 1'b1;
              result.anomaly     <= base_anomaly;
              result.entry_count <= base_count;
              result.dropped     <= 1'b1;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (tail.valid) begin
            state              <= IDLE;
            anomaly_seen       <= anomaly_seen | tail.hit;
            stored_count       <= CAP_W'(stored_count + 1'b1);
            result_valid       <= 1'b1;
            result.anomaly     <= anomaly_seen | tail.hit;
            result.entry_count <= CAP_W'(stored_count + 1'b1);
            result.dropped     <= 1'b0;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dmbd_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int STALL_LIMIT = 1000;
  localparam int GAP_CUTOFF = 1250;
  localparam int RANDOM_TARGET = 1400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start;
  logic busy;
  in_t request;
  logic result_valid;
  out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  // mirror of the table as the block should hold it
  logic [47:0] bound_mac [TABLE_DEPTH];
  logic [31:0] bound_ip [TABLE_DEPTH];
  int table_fill = 0;
  logic conflict_flag = 1'b0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;

  out_t pending_verdicts [$];
  out_t oldest_verdict;
  int mismatches = 0;
  int entries_sent = 0;
  int stall_cycles;
  bit sender_gaps = 1'b1;

  duplicate_mac_binding_detector #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_t apply_entry(input in_t req);
    out_t verdict;
    int limit;
    if (req.new_table) begin
      table_fill = 0;
      conflict_flag = 1'b0;
    end
    limit = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
    verdict.dropped = (table_fill >= limit);
    if (!verdict.dropped) begin
      if (req.mac_address != BCAST_MAC) begin
        for (int k = 0; k < table_fill; k++) begin
          if (bound_mac[k] == req.mac_address && bound_ip[k] != req.ip_address)
            conflict_flag = 1'b1;
        end
      end
      bound_mac[table_fill] = req.mac_address;
      bound_ip[table_fill] = req.ip_address;
      table_fill++;
    end
    verdict.anomaly = conflict_flag;
    verdict.entry_count = CAP_W'(table_fill);
    return verdict;
  endfunction

  task automatic send_entry(input logic fresh, input logic [31:0] ip, input logic [47:0] mac);
    in_t req;
    req = '{new_table: fresh, ip_address: ip, mac_address: mac};
    if (sender_gaps && entries_sent < GAP_CUTOFF && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(apply_entry(req));
    entries_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic test_bindings();
    send_entry(1'b1, 32'h0000_0000, 48'h0);
    send_entry(1'b0, 32'hFFFF_FFFF, BCAST_MAC);
    send_entry(1'b0, 32'h0000_0000, 48'h0);
    send_entry(1'b0, 32'h0000_0001, BCAST_MAC);
    send_entry(1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFE);
    send_entry(1'b0, 32'h0000_0001, 48'h0);
    send_entry(1'b0, 32'h0000_0002, 48'h1);
    send_entry(1'b1, 32'h0000_0005, 48'h0);
    send_entry(1'b0, 32'h0000_0006, 48'h0);
    drain();
  endtask

  task automatic test_capacity_extremes();
    logic [47:0] mac;
    mac = 48'($urandom) << 16 | 48'($urandom_range(0, 65535));
    write_capacity(7'd0);
    send_entry(1'b1, $urandom, mac);
    send_entry(1'b0, $urandom, mac);
    drain();
    write_capacity(7'd1);
    send_entry(1'b1, 32'hC0A8_0001, mac);
    send_entry(1'b0, 32'hC0A8_0002, mac);
    drain();
    write_capacity(7'd127);
    send_entry(1'b1, 32'hC0A8_0001, mac);
    send_entry(1'b0, 32'hC0A8_0002, mac);
    drain();
  endtask

  task automatic test_lowered_capacity();
    write_capacity(7'd64);
    send_entry(1'b1, 32'h0A00_0001, 48'h0200_0000_0001);
    send_entry(1'b0, 32'h0A00_0002, 48'h0200_0000_0002);
    send_entry(1'b0, 32'h0A00_0003, 48'h0200_0000_0003);
    send_entry(1'b0, 32'h0A00_0004, 48'h0200_0000_0004);
    drain();
    write_capacity(7'd2);
    send_entry(1'b0, 32'h0A00_0099, 48'h0200_0000_0001);
    drain();
    write_capacity(7'd6);
    send_entry(1'b0, 32'h0A00_0099, 48'h0200_0000_0001);
    send_entry(1'b0, 32'h0A00_0005, 48'h0200_0000_0005);
    send_entry(1'b0, 32'h0A00_0006, 48'h0200_0000_0006);
    drain();
  endtask

  task automatic test_random_tables(input int target);
    logic [47:0] mac_pool [8];
    logic [31:0] ip_pool [8];
    logic [CAP_W-1:0] new_cap;
    logic fresh;
    logic [47:0] mac;
    logic [31:0] ip;
    int span;
    int pick;
    int limit;
    bit noisy;
    bit clash;
    while (entries_sent < target) begin
      // pause until the block has answered every request
      drain();
      case ($urandom_range(0, 9))
        0: new_cap = 7'd0;
        1: new_cap = 7'd1;
        2: new_cap = 7'd64;
        3: new_cap = 7'd127;
        4: new_cap = CAP_W'($urandom_range(65, 126));
        default: new_cap = CAP_W'($urandom_range(2, 20));
      endcase
      write_capacity(new_cap);
      sender_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        foreach (mac_pool[i]) begin
          mac_pool[i] = 48'({$urandom, $urandom});
          ip_pool[i] = $urandom;
        end
        limit = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
        span = $urandom_range(1, limit + 4);
        noisy = ($urandom_range(0, 4) == 0);
        clash = ($urandom_range(0, 2) == 0);
        for (int n = 0; n < span; n++) begin
          if (noisy) begin
            fresh = ($urandom_range(0, 7) == 0);
            mac = 48'({$urandom, $urandom});
            ip = $urandom;
          end else begin
            fresh = (n == 0) && ($urandom_range(0, 7) != 0);
            pick = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
              0: mac = BCAST_MAC;
              1, 2: mac = 48'({$urandom, $urandom});
              default: mac = mac_pool[pick];
            endcase
            if (clash && $urandom_range(0, 3) == 0)
              ip = ip_pool[$urandom_range(0, 7)];
            else
              ip = ip_pool[pick];
          end
          send_entry(fresh, ip, mac);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (result.anomaly !== oldest_verdict.anomaly) begin
          $error("anomaly: expected %0d, got %0d", oldest_verdict.anomaly, result.anomaly);
          mismatches++;
        end
        if (result.entry_count !== oldest_verdict.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 oldest_verdict.entry_count, result.entry_count);
          mismatches++;
        end
        if (result.dropped !== oldest_verdict.dropped) begin
          $error("dropped: expected %0d, got %0d", oldest_verdict.dropped, result.dropped);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("duplicate_mac_binding_detector test failed");
    $finish;
  end

  initial begin
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_bindings();
    test_capacity_extremes();
    test_lowered_capacity();
    test_random_tables(entries_sent + RANDOM_TARGET);
    drain();
    repeat (TABLE_DEPTH + 5) @(posedge clk);
    if (pending_verdicts.size() != 0)
      $error("%0d results never arrived", pending_verdicts.size());
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("duplicate_mac_binding_detector test passed");
    else
      $display("duplicate_mac_binding_detector test failed");
    $finish;
  end

endmodule
